// File: rtl/core/pjsw_pkg.sv
// pjsw_pkg: shared widths, register codes, reset values and control types
// used by every module of the projection jacobian shape-weight pipeline
// depends on nothing
`default_nettype none
package pjsw_pkg;

  // default bounds of the streamed index ranges
  localparam int MAX_POINTS_DEF = 128;
  localparam int MAX_MODES_DEF  = 64;

  // data widths
  localparam int CRD_W  = 32;                 // Q16.16 coordinates
  localparam int ROT_W  = 16;                 // Q2.14 rotation entry
  localparam int ROW_W  = 3 * ROT_W;          // packed rotation row
  localparam int PR_W   = ROT_W + CRD_W;      // rotation product
  localparam int ACC_W  = 52;                 // row sum plus translation
  localparam int FRAC_D = 14;                 // bits dropped from Q.30
  localparam int P_W    = 36;                 // reduced camera coordinate
  localparam int HALF   = 18;                 // split point for wide products
  localparam int LO_W   = P_W + HALF + 1;
  localparam int HI_W   = P_W + HALF;
  localparam int FW     = 2 * P_W;            // full coordinate product
  localparam int NW     = FW + 1;             // signed numerator
  localparam int MW     = FW;                 // numerator magnitude
  localparam int CHK    = 24;                 // chunk of magnitude per multiply
  localparam int NCHK   = MW / CHK;
  localparam int PP_W   = CHK + CRD_W;
  localparam int DW     = MW + CRD_W;         // dividend width
  localparam int QB     = 31;                 // quotient bits below saturation

  localparam logic [CRD_W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [CRD_W-1:0] SAT_NEG = 32'h8000_0000;

  // configuration register codes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROT_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TRN_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRN_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TRN_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL = 3'd6;

  // identity rotation after reset
  localparam logic [ROW_W-1:0] ROT_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROT_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROT_Z_RST = 48'h4000_0000_0000;

  // control that travels with each beat
  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/projection_jacobian_shape_weights_top.sv
// projection_jacobian_shape_weights_top: shape-weight jacobian of a perspective
// projection, configuration registers and the three pipeline sections
// depends on pjsw_pkg, pjsw_xform, pjsw_numer, pjsw_div
//
// Usage:
// - input channel: raise in_start with a point, a basis column and the two
//   indices; the beat is taken at any edge where busy is low. busy never
//   rises, so a new beat may enter on every cycle.
// - result channel: out_strobe is high for one cycle with out_deriv_u,
//   out_deriv_v, the copied indices and out_zero_depth. The receiver cannot
//   stall; results leave in input order.
// - pipeline from the accepting edge to the strobe: rotation, numerator
//   products and focal scaling, then division (saturation check, one quotient
//   bit per stage over 31 stages, final clamp). Throughput is one beat per cycle.
// - configuration: cfg_we writes cfg_wdata to register cfg_index; write only
//   while no beat is in flight. Unknown indices are ignored.
// - reset (synchronous, rst_n low) clears all valid bits and loads the
//   identity rotation, zero translation and zero focal length.
`default_nettype none
module projection_jacobian_shape_weights_top #(
  parameter int MAX_POINTS = pjsw_pkg::MAX_POINTS_DEF,
  parameter int MAX_MODES  = pjsw_pkg::MAX_MODES_DEF,
  parameter int PIDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int MIDX_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_start,
  output logic                              busy,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_point_x,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_point_y,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_point_z,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_basis_x,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_basis_y,
  input  logic [pjsw_pkg::CRD_W-1:0]        in_basis_z,
  input  logic [PIDX_W-1:0]                 in_point_index,
  input  logic [MIDX_W-1:0]                 in_mode_index,
  output logic                              out_strobe,
  output logic [pjsw_pkg::CRD_W-1:0]        out_deriv_u,
  output logic [pjsw_pkg::CRD_W-1:0]        out_deriv_v,
  output logic [PIDX_W-1:0]                 out_point_index,
  output logic [MIDX_W-1:0]                 out_mode_index,
  output logic                              out_zero_depth,
  input  logic                              cfg_we,
  input  logic [pjsw_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pjsw_pkg::ROW_W-1:0]        cfg_wdata
);
  import pjsw_pkg::*;

  localparam int TAG_W = PIDX_W + MIDX_W;

  logic [ROW_W-1:0]          rot_x_r;
  logic [ROW_W-1:0]          rot_y_r;
  logic [ROW_W-1:0]          rot_z_r;
  logic [CRD_W-1:0]          trn_x_r;
  logic [CRD_W-1:0]          trn_y_r;
  logic [CRD_W-1:0]          trn_z_r;
  logic [CRD_W-1:0]          focal_r;
  logic                      acc_beat;
  logic [TAG_W-1:0]          tag_in;
  ctl_t                      ctl_x;
  logic [2:0][P_W-1:0]       p_x;
  logic [2:0][P_W-1:0]       q_x;
  logic [TAG_W-1:0]          tag_x;
  ctl_t                      ctl_n;
  logic [1:0][DW-1:0]        prod_n;
  logic [1:0]                neg_n;
  logic [MW-1:0]             den_n;
  logic [TAG_W-1:0]          tag_n;
  ctl_t                      ctl_d;
  logic [1:0][CRD_W-1:0]     deriv_d;
  logic [TAG_W-1:0]          tag_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= ROT_X_RST;
      rot_y_r <= ROT_Y_RST;
      rot_z_r <= ROT_Z_RST;
      trn_x_r <= '0;
      trn_y_r <= '0;
      trn_z_r <= '0;
      focal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_X: rot_x_r <= cfg_wdata;
        REG_ROT_Y: rot_y_r <= cfg_wdata;
        REG_ROT_Z: rot_z_r <= cfg_wdata;
        REG_TRN_X: trn_x_r <= cfg_wdata[CRD_W-1:0];
        REG_TRN_Y: trn_y_r <= cfg_wdata[CRD_W-1:0];
        REG_TRN_Z: trn_z_r <= cfg_wdata[CRD_W-1:0];
        REG_FOCAL: focal_r <= cfg_wdata[CRD_W-1:0];
        default: ;
      endcase
    end
  end

  // fully pipelined, never busy
  assign busy     = 1'b0;
  assign acc_beat = in_start & ~busy;
  assign tag_in   = {in_point_index, in_mode_index};

  pjsw_xform #(.TAG_W(TAG_W)) u_xform (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(acc_beat),
    .pnt   ({in_point_z, in_point_y, in_point_x}),
    .bas   ({in_basis_z, in_basis_y, in_basis_x}),
    .tag_i (tag_in),
    .rot   ({rot_z_r, rot_y_r, rot_x_r}),
    .trans ({trn_z_r, trn_y_r, trn_x_r}),
    .ctl_o (ctl_x),
    .p_o   (p_x),
    .q_o   (q_x),
    .tag_o (tag_x)
  );

  pjsw_numer #(.TAG_W(TAG_W)) u_numer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_x),
    .p_i   (p_x),
    .q_i   (q_x),
    .tag_i (tag_x),
    .focal (focal_r),
    .ctl_o (ctl_n),
    .prod_o(prod_n),
    .neg_o (neg_n),
    .den_o (den_n),
    .tag_o (tag_n)
  );

  pjsw_div #(.TAG_W(TAG_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_n),
    .prod_i (prod_n),
    .neg_i  (neg_n),
    .den_i  (den_n),
    .tag_i  (tag_n),
    .ctl_o  (ctl_d),
    .deriv_o(deriv_d),
    .tag_o  (tag_d)
  );

  // result beat
  assign out_strobe      = ctl_d.vld;
  assign out_zero_depth  = ctl_d.zero;
  assign out_deriv_u     = deriv_d[0];
  assign out_deriv_v     = deriv_d[1];
  assign out_point_index = tag_d[TAG_W-1:MIDX_W];
  assign out_mode_index  = tag_d[MIDX_W-1:0];

endmodule
`default_nettype wire

// File: rtl/core/pjsw_xform.sv
// pjsw_xform: rotates the model point and basis column and adds translation to the point
// two stages: rotation products, then row sums reduced to Q20.16
// depends on pjsw_pkg
`default_nettype none
module pjsw_xform #(
  parameter int TAG_W = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic [2:0][pjsw_pkg::CRD_W-1:0]      pnt,
  input  logic [2:0][pjsw_pkg::CRD_W-1:0]      bas,
  input  logic [TAG_W-1:0]                     tag_i,
  input  logic [2:0][pjsw_pkg::ROW_W-1:0]      rot,
  input  logic [2:0][pjsw_pkg::CRD_W-1:0]      trans,
  output pjsw_pkg::ctl_t                       ctl_o,
  output logic [2:0][pjsw_pkg::P_W-1:0]        p_o,
  output logic [2:0][pjsw_pkg::P_W-1:0]        q_o,
  output logic [TAG_W-1:0]                     tag_o
);
  import pjsw_pkg::*;

  logic signed [PR_W-1:0]  prod_s_r [3][3];
  logic signed [PR_W-1:0]  prod_b_r [3][3];
  logic                    vld_a_r;
  logic [TAG_W-1:0]        tag_a_r;
  logic signed [ACC_W-1:0] acc_p [3];
  logic signed [ACC_W-1:0] acc_q [3];
  logic [2:0][P_W-1:0]     p_nxt;
  logic [2:0][P_W-1:0]     q_nxt;
  logic [2:0][P_W-1:0]     p_r;
  logic [2:0][P_W-1:0]     q_r;
  logic                    vld_b_r;
  logic                    zero_r;
  logic [TAG_W-1:0]        tag_b_r;

  // stage a: nine rotation products each for point and basis
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod_s_r[k][c] <= $signed(rot[k][ROT_W*c +: ROT_W]) * $signed(pnt[c]);
        prod_b_r[k][c] <= $signed(rot[k][ROT_W*c +: ROT_W]) * $signed(bas[c]);
      end
    end
    tag_a_r <= tag_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
  end

  // stage b: row sums, translation, floor to Q20.16
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_p[k] = ACC_W'(prod_s_r[k][0]) + ACC_W'(prod_s_r[k][1]) + ACC_W'(prod_s_r[k][2])
               + (ACC_W'($signed(trans[k])) <<< FRAC_D);
      acc_q[k] = ACC_W'(prod_b_r[k][0]) + ACC_W'(prod_b_r[k][1]) + ACC_W'(prod_b_r[k][2]);
      p_nxt[k] = P_W'(acc_p[k] >>> FRAC_D);
      q_nxt[k] = P_W'(acc_q[k] >>> FRAC_D);
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    zero_r  <= (p_nxt[2] == '0);
    tag_b_r <= tag_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  assign ctl_o.vld  = vld_b_r;
  assign ctl_o.zero = zero_r;
  assign p_o        = p_r;
  assign q_o        = q_r;
  assign tag_o      = tag_b_r;

endmodule
`default_nettype wire

// File: rtl/core/pjsw_numer.sv
// pjsw_numer: forms the two numerators, depth squared, and scales by focal length
// five stages: split products, combine, magnitude, chunk multiply, chunk sum
// depends on pjsw_pkg
`default_nettype none
module pjsw_numer #(
  parameter int TAG_W = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pjsw_pkg::ctl_t                    ctl_i,
  input  logic [2:0][pjsw_pkg::P_W-1:0]     p_i,
  input  logic [2:0][pjsw_pkg::P_W-1:0]     q_i,
  input  logic [TAG_W-1:0]                  tag_i,
  input  logic [pjsw_pkg::CRD_W-1:0]        focal,
  output pjsw_pkg::ctl_t                    ctl_o,
  output logic [1:0][pjsw_pkg::DW-1:0]      prod_o,
  output logic [1:0]                        neg_o,
  output logic [pjsw_pkg::MW-1:0]           den_o,
  output logic [TAG_W-1:0]                  tag_o
);
  import pjsw_pkg::*;

  logic signed [P_W-1:0]  ma [5];
  logic signed [P_W-1:0]  mb [5];
  logic signed [LO_W-1:0] lo_r [5];
  logic signed [HI_W-1:0] hi_r [5];
  logic signed [FW-1:0]   full [5];
  logic signed [NW-1:0]   num_nxt [2];
  logic [1:0][NW-1:0]     num_r;
  logic [1:0][MW-1:0]     mag_r;
  logic [1:0]             neg_e_r;
  logic [1:0]             neg_f_r;
  logic [1:0]             neg_g_r;
  logic [PP_W-1:0]        part_r [2][NCHK];
  logic [1:0][DW-1:0]     prod_r;
  logic [MW-1:0]          den_d_r;
  logic [MW-1:0]          den_e_r;
  logic [MW-1:0]          den_f_r;
  logic [MW-1:0]          den_g_r;
  ctl_t                   ctl_c_r;
  ctl_t                   ctl_d_r;
  ctl_t                   ctl_e_r;
  ctl_t                   ctl_f_r;
  ctl_t                   ctl_g_r;
  logic [TAG_W-1:0]       tag_c_r;
  logic [TAG_W-1:0]       tag_d_r;
  logic [TAG_W-1:0]       tag_e_r;
  logic [TAG_W-1:0]       tag_f_r;
  logic [TAG_W-1:0]       tag_g_r;

  // operand pairs: qx*pz, px*qz, qy*pz, py*qz, pz*pz
  always_comb begin
    ma[0] = $signed(q_i[0]); mb[0] = $signed(p_i[2]);
    ma[1] = $signed(p_i[0]); mb[1] = $signed(q_i[2]);
    ma[2] = $signed(q_i[1]); mb[2] = $signed(p_i[2]);
    ma[3] = $signed(p_i[1]); mb[3] = $signed(q_i[2]);
    ma[4] = $signed(p_i[2]); mb[4] = $signed(p_i[2]);
  end

  // stage c: each wide product as low and high half partials
  always_ff @(posedge clk) begin
    for (int j = 0; j < 5; j++) begin
      lo_r[j] <= ma[j] * $signed({1'b0, mb[j][HALF-1:0]});
      hi_r[j] <= ma[j] * $signed(mb[j][P_W-1:HALF]);
    end
    tag_c_r       <= tag_i;
    ctl_c_r.zero  <= ctl_i.zero;
  end

  // stage d: combine halves, numerators and depth squared
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      full[j] = FW'(lo_r[j]) + (FW'(hi_r[j]) <<< HALF);
    end
    num_nxt[0] = NW'(full[0]) - NW'(full[1]);
    num_nxt[1] = NW'(full[2]) - NW'(full[3]);
  end

  always_ff @(posedge clk) begin
    num_r[0]     <= num_nxt[0];
    num_r[1]     <= num_nxt[1];
    den_d_r      <= full[4];
    tag_d_r      <= tag_c_r;
    ctl_d_r.zero <= ctl_c_r.zero;
  end

  // stage e: sign and magnitude
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      neg_e_r[l] <= num_r[l][NW-1];
      mag_r[l]   <= num_r[l][NW-1] ? MW'(-num_r[l]) : MW'(num_r[l]);
    end
    den_e_r      <= den_d_r;
    tag_e_r      <= tag_d_r;
    ctl_e_r.zero <= ctl_d_r.zero;
  end

  // stage f: magnitude times focal length in chunks
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      for (int c = 0; c < NCHK; c++) begin
        part_r[l][c] <= PP_W'(mag_r[l][CHK*c +: CHK]) * PP_W'(focal);
      end
    end
    neg_f_r      <= neg_e_r;
    den_f_r      <= den_e_r;
    tag_f_r      <= tag_e_r;
    ctl_f_r.zero <= ctl_e_r.zero;
  end

  // stage g: sum chunk products into the dividend
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      prod_r[l] <= DW'(part_r[l][0]) + (DW'(part_r[l][1]) << CHK)
                 + (DW'(part_r[l][2]) << (2 * CHK));
    end
    neg_g_r      <= neg_f_r;
    den_g_r      <= den_f_r;
    tag_g_r      <= tag_f_r;
    ctl_g_r.zero <= ctl_f_r.zero;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r.vld <= 1'b0;
      ctl_d_r.vld <= 1'b0;
      ctl_e_r.vld <= 1'b0;
      ctl_f_r.vld <= 1'b0;
      ctl_g_r.vld <= 1'b0;
    end else begin
      ctl_c_r.vld <= ctl_i.vld;
      ctl_d_r.vld <= ctl_c_r.vld;
      ctl_e_r.vld <= ctl_d_r.vld;
      ctl_f_r.vld <= ctl_e_r.vld;
      ctl_g_r.vld <= ctl_f_r.vld;
    end
  end

  assign ctl_o  = ctl_g_r;
  assign prod_o = prod_r;
  assign neg_o  = neg_g_r;
  assign den_o  = den_g_r;
  assign tag_o  = tag_g_r;

endmodule
`default_nettype wire

// File: rtl/core/pjsw_div.sv
// pjsw_div: pipelined restoring divider for both derivative lanes
// saturation check stage, one quotient bit per stage, then sign, clamp and zero depth
// depends on pjsw_pkg
`default_nettype none
module pjsw_div #(
  parameter int TAG_W = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pjsw_pkg::ctl_t                    ctl_i,
  input  logic [1:0][pjsw_pkg::DW-1:0]      prod_i,
  input  logic [1:0]                        neg_i,
  input  logic [pjsw_pkg::MW-1:0]           den_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output pjsw_pkg::ctl_t                    ctl_o,
  output logic [1:0][pjsw_pkg::CRD_W-1:0]   deriv_o,
  output logic [TAG_W-1:0]                  tag_o
);
  import pjsw_pkg::*;

  logic [1:0][DW-1:0]  rem_r  [QB+1];
  logic [1:0][QB-1:0]  quo_r  [QB+1];
  logic [1:0]          sat_r  [QB+1];
  logic [1:0]          neg_r  [QB+1];
  logic [MW-1:0]       den_r  [QB+1];
  ctl_t                ctl_r  [QB+1];
  logic [TAG_W-1:0]    tag_r  [QB+1];
  logic [DW-1:0]       den_top;
  logic [1:0][CRD_W-1:0] res_nxt;
  logic [1:0][CRD_W-1:0] res_r;
  ctl_t                ctl_out_r;
  logic [TAG_W-1:0]    tag_out_r;

  // stage h: quotient of 2^31 or more saturates
  assign den_top = DW'(den_i) << QB;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      sat_r[0][l] <= (prod_i[l] >= den_top);
      rem_r[0][l] <= prod_i[l];
      quo_r[0][l] <= '0;
    end
    neg_r[0]      <= neg_i;
    den_r[0]      <= den_i;
    tag_r[0]      <= tag_i;
    ctl_r[0].zero <= ctl_i.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].vld <= 1'b0;
    end else begin
      ctl_r[0].vld <= ctl_i.vld;
    end
  end

  // one compare and subtract per stage, most significant bit first
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW-1:0] dsh;
    logic [1:0]    ge;

    assign dsh = DW'(den_r[s-1]) << (QB - s);

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        ge[l] = (rem_r[s-1][l] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[s][l] <= ge[l] ? (rem_r[s-1][l] - dsh) : rem_r[s-1][l];
        quo_r[s][l] <= {quo_r[s-1][l][QB-2:0], ge[l]};
      end
      sat_r[s]      <= sat_r[s-1];
      neg_r[s]      <= neg_r[s-1];
      den_r[s]      <= den_r[s-1];
      tag_r[s]      <= tag_r[s-1];
      ctl_r[s].zero <= ctl_r[s-1].zero;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].vld <= 1'b0;
      end else begin
        ctl_r[s].vld <= ctl_r[s-1].vld;
      end
    end
  end

  // sign, clamp and zero depth
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (ctl_r[QB].zero) begin
        res_nxt[l] = '0;
      end else if (sat_r[QB][l]) begin
        res_nxt[l] = neg_r[QB][l] ? SAT_NEG : SAT_POS;
      end else if (neg_r[QB][l]) begin
        res_nxt[l] = CRD_W'(-{1'b0, quo_r[QB][l]});
      end else begin
        res_nxt[l] = CRD_W'({1'b0, quo_r[QB][l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r          <= res_nxt;
    tag_out_r      <= tag_r[QB];
    ctl_out_r.zero <= ctl_r[QB].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r.vld <= 1'b0;
    end else begin
      ctl_out_r.vld <= ctl_r[QB].vld;
    end
  end

  assign ctl_o   = ctl_out_r;
  assign deriv_o = res_r;
  assign tag_o   = tag_out_r;

endmodule
`default_nettype wire

// File: dv/projection_jacobian_shape_weights_top_tb.sv
// testbench for projection_jacobian_shape_weights_top: random and directed beats,
// each result checked field by field against a predictor of the jacobian
// depends on pjsw_pkg and projection_jacobian_shape_weights_top
`timescale 1ns / 1ps
module projection_jacobian_shape_weights_top_tb;
  import pjsw_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYC = 45;

  typedef struct {
    logic signed [31:0] sx, sy, sz, bx, by, bz;
    logic [6:0] pidx;
    logic [5:0] midx;
  } pair_t;

  typedef struct {
    logic [31:0] du, dv;
    logic [6:0] pidx;
    logic [5:0] midx;
    logic zd;
  } jac_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic busy;
  logic [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [31:0] in_basis_x = '0, in_basis_y = '0, in_basis_z = '0;
  logic [6:0] in_point_index = '0;
  logic [5:0] in_mode_index = '0;
  logic out_strobe, out_zero_depth;
  logic [31:0] out_deriv_u, out_deriv_v;
  logic [6:0] out_point_index;
  logic [5:0] out_mode_index;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  logic [47:0] m_rot_x = ROT_X_RST, m_rot_y = ROT_Y_RST, m_rot_z = ROT_Z_RST;
  logic signed [31:0] m_tx = 0, m_ty = 0, m_tz = 0;
  logic [31:0] m_focal = 0;

  pair_t pending_pairs[$];
  jac_t  jac_expected[$];
  pair_t on_port;
  bit no_idle = 0;
  int errors = 0, n_checked = 0, n_zero = 0, n_sat = 0;

  projection_jacobian_shape_weights_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one rotation row times a vector plus translation, floor-reduced to Q48.16
  function automatic longint rotate_row(logic [47:0] row, logic signed [31:0] a,
      logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] t);
    longint acc;
    acc = longint'($signed(row[15:0])) * longint'(a)
        + longint'($signed(row[31:16])) * longint'(b)
        + longint'($signed(row[47:32])) * longint'(c)
        + (longint'(t) <<< 14);
    return acc >>> 14;
  endfunction

  // f*(qa*pz - pa*qz)/pz^2 truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] image_deriv(longint qa, longint pa, longint pz,
      longint qz);
    logic signed [127:0] num, qa_w, pa_w, pz_w, qz_w;
    logic [127:0] mag, den, quo;
    logic neg;
    qa_w = qa; pa_w = pa; pz_w = pz; qz_w = qz;
    num = qa_w * pz_w - pa_w * qz_w;
    neg = num[127];
    mag = neg ? -num : num;
    den = pz_w * pz_w;
    quo = (mag * {96'd0, m_focal}) / den;
    if (neg) return (quo >= 128'h8000_0000) ? SAT_NEG : -quo[31:0];
    return (quo > 128'h7fff_ffff) ? SAT_POS : quo[31:0];
  endfunction

  function automatic jac_t shape_jacobian(pair_t it);
    jac_t r;
    longint px, py, pz, qx, qy, qz;
    px = rotate_row(m_rot_x, it.sx, it.sy, it.sz, m_tx);
    py = rotate_row(m_rot_y, it.sx, it.sy, it.sz, m_ty);
    pz = rotate_row(m_rot_z, it.sx, it.sy, it.sz, m_tz);
    qx = rotate_row(m_rot_x, it.bx, it.by, it.bz, 0);
    qy = rotate_row(m_rot_y, it.bx, it.by, it.bz, 0);
    qz = rotate_row(m_rot_z, it.bx, it.by, it.bz, 0);
    r.pidx = it.pidx;
    r.midx = it.midx;
    r.zd = (pz == 0);
    r.du = r.zd ? 32'd0 : image_deriv(qx, px, pz, qz);
    r.dv = r.zd ? 32'd0 : image_deriv(qy, py, pz, qz);
    return r;
  endfunction

  // driver: a beat is taken when in_start is high and busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      in_start <= 1'b0;
    end else begin
      if (in_start && !busy)
        jac_expected.insert(jac_expected.size(), shape_jacobian(on_port));
      if (!in_start || !busy) begin
        if (pending_pairs.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
          on_port = pending_pairs.pop_front();
          in_point_x <= on_port.sx;
          in_point_y <= on_port.sy;
          in_point_z <= on_port.sz;
          in_basis_x <= on_port.bx;
          in_basis_y <= on_port.by;
          in_basis_z <= on_port.bz;
          in_point_index <= on_port.pidx;
          in_mode_index <= on_port.midx;
          in_start <= 1'b1;
        end else begin
          in_start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    jac_t e;
    if (rst_n && out_strobe) begin
      if (jac_expected.size() == 0) begin
        $display("%0t: unexpected result beat u=%h v=%h", $time, out_deriv_u,
                 out_deriv_v);
        errors++;
      end else begin
        e = jac_expected.pop_front();
        n_checked++;
        if (e.zd) n_zero++;
        if (e.du == SAT_POS || e.du == SAT_NEG) n_sat++;
        if (out_deriv_u !== e.du) begin
          $display("%0t: deriv_u expected %h actual %h", $time, e.du, out_deriv_u);
          errors++;
        end
        if (out_deriv_v !== e.dv) begin
          $display("%0t: deriv_v expected %h actual %h", $time, e.dv, out_deriv_v);
          errors++;
        end
        if (out_point_index !== e.pidx) begin
          $display("%0t: point_index expected %h actual %h", $time, e.pidx,
                   out_point_index);
          errors++;
        end
        if (out_mode_index !== e.midx) begin
          $display("%0t: mode_index expected %h actual %h", $time, e.midx,
                   out_mode_index);
          errors++;
        end
        if (out_zero_depth !== e.zd) begin
          $display("%0t: zero_depth expected %b actual %b", $time, e.zd,
                   out_zero_depth);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [47:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROT_X: m_rot_x = data;
      REG_ROT_Y: m_rot_y = data;
      REG_ROT_Z: m_rot_z = data;
      REG_TRN_X: m_tx = data[31:0];
      REG_TRN_Y: m_ty = data[31:0];
      REG_TRN_Z: m_tz = data[31:0];
      REG_FOCAL: m_focal = data[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pose(logic [47:0] rx, ry, rz, logic [31:0] tx, ty, tz, f);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_TRN_X, {16'd0, tx});
    write_reg(REG_TRN_Y, {16'd0, ty});
    write_reg(REG_TRN_Z, {16'd0, tz});
    write_reg(REG_FOCAL, {16'd0, f});
  endtask

  // wait until every queued beat is in and every result is back
  task automatic drain();
    while (pending_pairs.size() > 0 || in_start || jac_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(32'h0028_0000)) - 32'sh0014_0000;
  endfunction

  function automatic pair_t random_pair(bit wide);
    pair_t p;
    p.sx = coord(wide); p.sy = coord(wide); p.sz = coord(wide);
    p.bx = coord(wide); p.by = coord(wide); p.bz = coord(wide);
    p.pidx = 7'($urandom); p.midx = 6'($urandom);
    return p;
  endfunction

  function automatic logic [47:0] random_rot();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] near_rot(int lane);
    logic [47:0] r;
    r = '0;
    for (int i = 0; i < 3; i++)
      r[16*i +: 16] = 16'((i == lane ? 16'sh3800 : 16'sh0000)
                      + $signed($urandom_range(16'h1000)) - 16'sh0800);
    return r;
  endfunction

  task automatic push_random(int n, int wide_pct);
    for (int i = 0; i < n; i++)
      pending_pairs.insert(pending_pairs.size(),
                           random_pair($urandom_range(99) < wide_pct));
  endtask

  task automatic push_pair(logic [31:0] sx, sy, sz, bx, by, bz, logic [6:0] pi,
      logic [5:0] mi);
    pair_t p;
    p.sx = sx; p.sy = sy; p.sz = sz; p.bx = bx; p.by = by; p.bz = bz;
    p.pidx = pi; p.midx = mi;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset pose, focal zero first, then unit focal
    push_pair(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
    drain();
    write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
    write_reg(REG_FOCAL, 48'h0001_0000);
    push_pair(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 1, 1);
    // zero depth and the smallest nonzero depths
    push_pair(32'h1234_5678, 32'h8765_4321, 0, 32'h7fff_ffff, 1, 2, 7'h7f, 6'h3f);
    push_pair(5, 7, 1, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 2, 2);
    push_pair(5, 7, 32'hffff_ffff, 1, 1, 1, 3, 3);
    // field extremes
    push_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 7'h7f, 6'h3f);
    push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 0, 0);
    push_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 7'h55, 6'h2a);
    push_pair(32'h0010_0000, 32'hfff0_0000, 32'h0000_0100, 32'h7fff_ffff,
              32'h8000_0000, 0, 7'h2a, 6'h15);
    push_pair(0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 9, 9);
    drain();

    // extreme pose: all entries most negative, translation and focal at limits
    set_pose(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    push_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff,
              32'h8000_0000, 4, 4);
    push_pair(0, 0, 0, 0, 0, 0, 5, 5);
    drain();
    set_pose(48'h7fff_7fff_7fff, 48'hffff_ffff_ffff, 48'h0000_0000_0001,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
    push_pair(32'h7fff_ffff, 1, 32'h8000_0000, 32'h8000_0000, 0, 1, 6, 6);
    push_random(8, 100);
    drain();

    // random phases, realistic poses with a depth offset and some noise, the last phase fully random
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_pose(random_rot(), random_rot(), random_rot(), $urandom, $urandom,
                 $urandom, $urandom);
      else
        set_pose(near_rot(0), near_rot(1), near_rot(2),
                 coord(0), coord(0), 32'h0020_0000 + $urandom_range(32'h0400_0000),
                 $urandom_range(32'h0400_0000));
      no_idle = (ph == 1);
      if (ph == 2) begin
        // sender holds off until the pipeline is empty between chunks
        for (int c = 0; c < 6; c++) begin
          push_random(48, 15);
          drain();
        end
      end else begin
        push_random(ph == 5 ? 200 : 300, 15);
      end
      drain();
    end
    no_idle = 0;

    $display("checked %0d results over several poses: %0d at zero depth, %0d saturated u",
             n_checked, n_zero, n_sat);
    if (errors == 0 && jac_expected.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
